FILE: rtl/dwc_pkg.sv
// Shared types and constants for the deque with cursor.
`default_nettype none
package dwc_pkg;

	localparam int FUNC_W  = 4;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = 5;

	typedef enum logic [FUNC_W-1:0] {
		CMD_PUSH_FRONT = 4'd0,
		CMD_PUSH_BACK  = 4'd1,
		CMD_POP_FRONT  = 4'd2,
		CMD_POP_BACK   = 4'd3,
		CMD_START      = 4'd4,
		CMD_END        = 4'd5,
		CMD_NEXT       = 4'd6,
		CMD_PREV       = 4'd7,
		CMD_READ       = 4'd8,
		CMD_CLEAR      = 4'd9
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_END   = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/dwc_if.sv
// Request and response channel interfaces of the deque with cursor.
`default_nettype none
interface dwc_req_if;
	logic                       valid;
	logic                       ready;
	logic [dwc_pkg::FUNC_W-1:0]  func;
	logic [dwc_pkg::VALUE_W-1:0] value_in;

	modport source (output valid, output func, output value_in, input ready);
	modport sink   (input valid, input func, input value_in, output ready);
endinterface

interface dwc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [dwc_pkg::STAT_W-1:0]  status;
	logic [dwc_pkg::VALUE_W-1:0] value_out;
	logic [dwc_pkg::LEN_W-1:0]   length;

	modport source (output valid, output status, output value_out, output length, input ready);
	modport sink   (input valid, input status, input value_out, input length, output ready);
endinterface
`default_nettype wire

FILE: rtl/deque_with_cursor_unit.sv
// Top level of the bounded double-ended queue with a cursor.
`default_nettype none
// A bounded double-ended queue of DEPTH words kept as a ring in a single-port
// store, with one cursor that walks the stored entries. Every request returns
// exactly one response of status, value and length. A request goes through
// these steps from acceptance until its response is loaded into the output
// register: it is captured, then the pointers are updated and the store is
// accessed, and then the registered store read reaches the output register.
// A new request is accepted only once the last one has been loaded into the
// output register; a response still waiting at the output does not block the
// next request, only the loading of its response. The store needs no clearing
// after reset, since only entries written by a push are ever read.
module deque_with_cursor_unit #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	dwc_req_if.sink   req,
	dwc_rsp_if.source rsp
);

	dwc_pkg::ctrl_t ctrl;

	dwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctrl      (ctrl)
	);

	dwc_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.func      (req.func),
		.value_in  (req.value_in),
		.status    (rsp.status),
		.value_out (rsp.value_out),
		.length    (rsp.length)
	);

endmodule
`default_nettype wire

FILE: rtl/dwc_ctrl.sv
// Sequencing state machine of the deque with cursor.
`default_nettype none
module dwc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output dwc_pkg::ctrl_t      ctrl
);

	dwc_pkg::state_t state_q;
	dwc_pkg::state_t state_n;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			dwc_pkg::ST_IDLE: begin
				if (req_valid) state_n = dwc_pkg::ST_EXEC;
			end
			dwc_pkg::ST_EXEC: begin
				state_n = dwc_pkg::ST_LOAD;
			end
			dwc_pkg::ST_LOAD: begin
				if (out_free) state_n = dwc_pkg::ST_IDLE;
			end
			default: begin
				state_n = dwc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		ctrl.capture = 1'b0;
		ctrl.exec    = 1'b0;
		ctrl.load    = 1'b0;
		unique case (state_q)
			dwc_pkg::ST_IDLE: begin
				req_ready    = 1'b1;
				ctrl.capture = req_valid;
			end
			dwc_pkg::ST_EXEC: begin
				ctrl.exec = 1'b1;
			end
			dwc_pkg::ST_LOAD: begin
				ctrl.load = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dwc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/dwc_datapath.sv
// Ring store, pointers, cursor and result register of the deque with cursor.
`default_nettype none
module dwc_datapath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dwc_pkg::ctrl_t              ctrl,
	input  wire logic [dwc_pkg::FUNC_W-1:0]  func,
	input  wire logic [dwc_pkg::VALUE_W-1:0] value_in,
	output logic [dwc_pkg::STAT_W-1:0]       status,
	output logic [dwc_pkg::VALUE_W-1:0]      value_out,
	output logic [dwc_pkg::LEN_W-1:0]        length
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	dwc_pkg::cmd_t               func_q;
	logic [dwc_pkg::VALUE_W-1:0] data_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] cur_q;
	logic          cv_q;

	logic [AW-1:0] head_n;
	logic [CW-1:0] count_n;
	logic [AW-1:0] cur_n;
	logic          cv_n;

	logic            full;
	logic            empty;
	logic [AW-1:0]   head_inc;
	logic [AW-1:0]   head_dec;
	logic [AW-1:0]   cur_inc;
	logic [AW-1:0]   cur_dec;
	logic [SW-1:0]   tail_sum;
	logic [SW-1:0]   push_sum;
	logic [AW-1:0]   tail;
	logic [AW-1:0]   push_slot;
	logic            cursor_cmd;

	dwc_pkg::stat_t  stat_n;
	logic [AW-1:0]   rd_addr;
	logic            use_rd;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [63:0]     win;
	logic [DATA_WIDTH-1:0] wdata;

	logic [DATA_WIDTH-1:0] rdata_q;
	dwc_pkg::stat_t        stat_q;
	logic                  use_rd_q;
	logic [63:0]           rwide;
	logic [15:0]           len_wide;

	logic [dwc_pkg::STAT_W-1:0]  out_status_q;
	logic [dwc_pkg::VALUE_W-1:0] out_value_q;
	logic [dwc_pkg::LEN_W-1:0]   out_length_q;

	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);

	assign head_inc = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? LAST : head_q - AW'(1);
	assign cur_inc  = (cur_q == LAST) ? '0 : cur_q + AW'(1);
	assign cur_dec  = (cur_q == '0) ? LAST : cur_q - AW'(1);

	// The tail is only used while the ring holds at least one entry.
	assign tail_sum  = SW'(head_q) + SW'(count_q) - SW'(1);
	assign push_sum  = SW'(head_q) + SW'(count_q);
	assign tail      = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
	assign push_slot = (push_sum >= DEPTH_S) ? AW'(push_sum - DEPTH_S) : AW'(push_sum);

	assign cursor_cmd = func_q inside {dwc_pkg::CMD_START, dwc_pkg::CMD_END,
		dwc_pkg::CMD_NEXT, dwc_pkg::CMD_PREV, dwc_pkg::CMD_READ};

	assign win   = 64'(data_q);
	assign wdata = win[DATA_WIDTH-1:0];

	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		cur_n   = cur_q;
		cv_n    = cv_q;
		stat_n  = dwc_pkg::STAT_OK;
		rd_addr = head_q;
		use_rd  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = head_dec;
		unique case (func_q)
			dwc_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					stat_n = dwc_pkg::STAT_FULL;
				end else begin
					head_n  = head_dec;
					wr_en   = 1'b1;
					wr_addr = head_dec;
					count_n = count_q + CW'(1);
				end
			end
			dwc_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					stat_n = dwc_pkg::STAT_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = push_slot;
					count_n = count_q + CW'(1);
				end
			end
			dwc_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					stat_n = dwc_pkg::STAT_EMPTY;
				end else begin
					rd_addr = head_q;
					use_rd  = 1'b1;
					if (cv_q && cur_q == head_q) cv_n = 1'b0;
					head_n  = head_inc;
					count_n = count_q - CW'(1);
				end
			end
			dwc_pkg::CMD_POP_BACK: begin
				if (empty) begin
					stat_n = dwc_pkg::STAT_EMPTY;
				end else begin
					rd_addr = tail;
					use_rd  = 1'b1;
					if (cv_q && cur_q == tail) cv_n = 1'b0;
					count_n = count_q - CW'(1);
				end
			end
			dwc_pkg::CMD_START: begin
				if (empty) begin
					cv_n = 1'b0;
				end else begin
					cur_n = head_q;
					cv_n  = 1'b1;
				end
			end
			dwc_pkg::CMD_END: begin
				if (empty) begin
					cv_n = 1'b0;
				end else begin
					cur_n = tail;
					cv_n  = 1'b1;
				end
			end
			dwc_pkg::CMD_NEXT: begin
				if (cv_q) begin
					if (empty || cur_q == tail) cv_n = 1'b0;
					else cur_n = cur_inc;
				end
			end
			dwc_pkg::CMD_PREV: begin
				if (cv_q) begin
					if (empty || cur_q == head_q) cv_n = 1'b0;
					else cur_n = cur_dec;
				end
			end
			dwc_pkg::CMD_READ: begin
				cv_n = cv_q;
			end
			dwc_pkg::CMD_CLEAR: begin
				head_n  = '0;
				count_n = '0;
				cur_n   = '0;
				cv_n    = 1'b0;
			end
			default: begin
				stat_n = dwc_pkg::STAT_OK;
			end
		endcase

		// Cursor commands report the entry the cursor lands on.
		if (cursor_cmd) begin
			if (cv_n) begin
				rd_addr = cur_n;
				use_rd  = 1'b1;
			end else begin
				stat_n = dwc_pkg::STAT_END;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			func_q <= dwc_pkg::cmd_t'(func);
			data_q <= value_in;
		end
	end

	// A request either writes or reads the store, never both.
	always_ff @(posedge clk) begin
		if (ctrl.exec && wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (ctrl.exec && use_rd) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			cur_q   <= '0;
			cv_q    <= 1'b0;
		end else if (ctrl.exec) begin
			head_q  <= head_n;
			count_q <= count_n;
			cur_q   <= cur_n;
			cv_q    <= cv_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			stat_q   <= stat_n;
			use_rd_q <= use_rd;
		end
	end

	assign rwide    = 64'(rdata_q);
	assign len_wide = 16'(count_q);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			out_status_q <= stat_q;
			out_value_q  <= use_rd_q ? rwide[dwc_pkg::VALUE_W-1:0] : '0;
			out_length_q <= len_wide[dwc_pkg::LEN_W-1:0];
		end
	end

	assign status    = out_status_q;
	assign value_out = out_value_q;
	assign length    = out_length_q;

endmodule
`default_nettype wire

FILE: rtl/dwc_checker.sv
// Port-level checks of the deque with cursor and their binding to the top level.
`default_nettype none
module dwc_checker #(
	parameter int DEPTH = 16
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [dwc_pkg::STAT_W-1:0]  status,
	input wire logic [dwc_pkg::VALUE_W-1:0] value_out,
	input wire logic [dwc_pkg::LEN_W-1:0]   length
);

	localparam logic [dwc_pkg::LEN_W-1:0] DEPTH_LEN = dwc_pkg::LEN_W'(DEPTH);

	// A waiting response must stay offered until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// Requests are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// A full report means the ring holds DEPTH entries.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == dwc_pkg::STAT_FULL |-> length == DEPTH_LEN)
		else $error("full reported with wrong length");

	// An empty report means nothing is stored and no value comes back.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == dwc_pkg::STAT_EMPTY |-> length == '0 && value_out == '0)
		else $error("empty reported with entries or a value");

	// A cursor at end never carries a value.
	a_end_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == dwc_pkg::STAT_END |-> value_out == '0)
		else $error("cursor end reported with a value");

endmodule

bind deque_with_cursor_unit dwc_checker #(.DEPTH(DEPTH)) u_dwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.value_out (rsp.value_out),
	.length    (rsp.length)
);
`default_nettype wire
